// ----- hw/rtl/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths, class codes and pipeline sideband types.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    // Coefficient and result widths.
    localparam int COEF_W        = 16;
    localparam int ROOT_W        = 33;
    localparam int DISC_W        = 34;
    localparam int DEN_W         = 17;
    localparam int FRAC_BITS_DEF = 16;
    localparam int INT_PAIRS     = 17;

    // Class codes.
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_ONE   = 2'd1;
    localparam logic [1:0] CLS_TWO   = 2'd2;
    localparam logic [1:0] CLS_DEGEN = 2'd3;

    // Sideband that travels with a word through the square-root cells.
    typedef struct packed {
        logic                     valid;
        logic [1:0]               cls;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
    } sq_side_t;

    // Sideband that travels with a word through the divider cells.
    typedef struct packed {
        logic             valid;
        logic [1:0]       cls;
        logic             neg_p;
        logic             neg_m;
        logic [DEN_W-1:0] den;
    } dv_side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/qrs_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square-root cell
// One digit-by-digit square-root step; registers its result for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell #(
    parameter int RT_W = 33
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       en,
    input  qrs_pkg::sq_side_t         side_in,
    input  wire [qrs_pkg::DISC_W-1:0] d_in,
    input  wire [RT_W-1:0]            root_in,
    input  wire [RT_W+2:0]            rem_in,
    output qrs_pkg::sq_side_t         side_out,
    output wire [qrs_pkg::DISC_W-1:0] d_out,
    output wire [RT_W-1:0]            root_out,
    output wire [RT_W+2:0]            rem_out
);

    localparam int REM_W = RT_W + 3;

    qrs_pkg::sq_side_t         side_reg;
    logic [qrs_pkg::DISC_W-1:0] d_reg, d_next;
    logic [RT_W-1:0]           root_reg, root_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [REM_W-1:0]          rem_sh;
    logic [REM_W-1:0]          trial;

    // Bring down the next bit pair and try to subtract 4*root+1.
    always_comb begin
        rem_sh = {rem_in[REM_W-3:0], d_in[qrs_pkg::DISC_W-1 -: 2]};
        trial  = {1'b0, root_in, 2'b01};
        d_next = {d_in[qrs_pkg::DISC_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[RT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_in[RT_W-2:0], 1'b0};
        end
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg.valid <= side_in.valid;
        end
        if (en) begin
            side_reg.cls <= side_in.cls;
            side_reg.a   <= side_in.a;
            side_reg.b   <= side_in.b;
            d_reg        <= d_next;
            root_reg     <= root_next;
            rem_reg      <= rem_next;
        end
    end

    assign side_out = side_reg;
    assign d_out    = d_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/qrs_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step for both roots; registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell #(
    parameter int MAG_W = 34
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  qrs_pkg::dv_side_t            side_in,
    input  wire [1:0][MAG_W-1:0]         dvd_in,
    input  wire [1:0][MAG_W-1:0]         quo_in,
    input  wire [1:0][qrs_pkg::DEN_W-1:0] rem_in,
    output qrs_pkg::dv_side_t            side_out,
    output wire [1:0][MAG_W-1:0]         dvd_out,
    output wire [1:0][MAG_W-1:0]         quo_out,
    output wire [1:0][qrs_pkg::DEN_W-1:0] rem_out
);

    localparam int DW = qrs_pkg::DEN_W;

    qrs_pkg::dv_side_t     side_reg;
    logic [1:0][MAG_W-1:0] dvd_reg, dvd_next;
    logic [1:0][MAG_W-1:0] quo_reg, quo_next;
    logic [1:0][DW-1:0]    rem_reg, rem_next;
    logic [1:0][DW:0]      rem_sh;
    logic [1:0][DW:0]      diff;

    // Shift in the next dividend bit and subtract the divisor where it fits.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rem_sh[l]   = {rem_in[l], dvd_in[l][MAG_W-1]};
            diff[l]     = rem_sh[l] - {1'b0, side_in.den};
            dvd_next[l] = {dvd_in[l][MAG_W-2:0], 1'b0};
            if (rem_sh[l] >= {1'b0, side_in.den}) begin
                rem_next[l] = diff[l][DW-1:0];
                quo_next[l] = {quo_in[l][MAG_W-2:0], 1'b1};
            end else begin
                rem_next[l] = rem_sh[l][DW-1:0];
                quo_next[l] = {quo_in[l][MAG_W-2:0], 1'b0};
            end
        end
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg.valid <= side_in.valid;
        end
        if (en) begin
            side_reg.cls   <= side_in.cls;
            side_reg.neg_p <= side_in.neg_p;
            side_reg.neg_m <= side_in.neg_m;
            side_reg.den   <= side_in.den;
            dvd_reg        <= dvd_next;
            quo_reg        <= quo_next;
            rem_reg        <= rem_next;
        end
    end

    assign side_out = side_reg;
    assign dvd_out  = dvd_reg;
    assign quo_out  = quo_reg;
    assign rem_out  = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/quadratic_root_solver.sv -----
// Throughput: one word per cycle; the pipeline moves whenever the output
// register is empty or being taken, so s_tready follows m_tready.
// Depth is set by the chain of square-root cells (17+FRAC_BITS) and the chain
// of divider cells (18+FRAC_BITS), one bit per cell.
// Reset (aresetn low, synchronous) clears every valid bit; data is not cleared.
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2+b*x+c in signed fixed point, one equation per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    // s_tdata: coef_a [15:0], coef_b [31:16], coef_c [47:32]
    input  wire        s_tvalid,
    output wire        s_tready,
    input  wire [47:0] s_tdata,
    // m_tdata: root_plus [32:0], root_minus [65:33], zero [71:66]
    output wire        m_tvalid,
    input  wire        m_tready,
    output wire [71:0] m_tdata,
    // m_tuser: root_class [1:0]
    output wire [1:0]  m_tuser
);

    localparam int CW      = qrs_pkg::COEF_W;
    localparam int RW      = qrs_pkg::ROOT_W;
    localparam int DW      = qrs_pkg::DEN_W;
    localparam int SQ_STEPS = qrs_pkg::INT_PAIRS + FRAC_BITS;
    localparam int RT_W    = SQ_STEPS;
    localparam int MAG_W   = FRAC_BITS + 18;
    localparam int NUM_W   = FRAC_BITS + 19;
    localparam int EXT_W   = (MAG_W + 1 > RW) ? MAG_W + 1 : RW;

    logic adv;

    // Input and product stages.
    logic                 v0_reg, v1_reg;
    logic signed [CW-1:0] a0_reg, b0_reg, c0_reg, a1_reg, b1_reg;
    logic signed [2*CW-1:0] bb_reg, ac_reg;

    // Discriminant stage.
    logic signed [2*CW+2:0] disc;
    logic [1:0]             cls_next;
    qrs_pkg::sq_side_t      sq_side [SQ_STEPS+1];
    logic [qrs_pkg::DISC_W-1:0] sq_d [SQ_STEPS+1];
    logic [RT_W-1:0]        sq_root [SQ_STEPS+1];
    logic [RT_W+2:0]        sq_rem  [SQ_STEPS+1];

    // Numerator stage and divider chain.
    logic signed [NUM_W-1:0] numb, nump, numm;
    logic signed [DW:0]      twice_a;
    qrs_pkg::dv_side_t       dv_side [MAG_W+1];
    logic [1:0][MAG_W-1:0]   dv_dvd  [MAG_W+1];
    logic [1:0][MAG_W-1:0]   dv_quo  [MAG_W+1];
    logic [1:0][DW-1:0]      dv_rem  [MAG_W+1];

    // Output stage.
    logic [EXT_W-1:0] qp_ext, qm_ext;
    logic [RW-1:0]    plus_next, minus_next;
    logic             out_valid_reg;
    logic [1:0]       out_cls_reg;
    logic [RW-1:0]    out_plus_reg, out_minus_reg;

    assign adv      = m_tready | ~out_valid_reg;
    assign s_tready = adv;

    // Capture the coefficients, then form b*b and a*c.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
        end
        if (adv) begin
            a0_reg <= s_tdata[15:0];
            b0_reg <= s_tdata[31:16];
            c0_reg <= s_tdata[47:32];
            a1_reg <= a0_reg;
            b1_reg <= b0_reg;
            bb_reg <= b0_reg * b0_reg;
            ac_reg <= a0_reg * c0_reg;
        end
    end

    // Discriminant and class; a negative discriminant feeds zero to the root.
    always_comb begin
        disc = {{3{bb_reg[2*CW-1]}}, bb_reg} - {ac_reg[2*CW-1], ac_reg, 2'b00};
        if (a1_reg == '0) begin
            cls_next = qrs_pkg::CLS_DEGEN;
        end else if (disc[2*CW+2]) begin
            cls_next = qrs_pkg::CLS_NONE;
        end else if (disc == '0) begin
            cls_next = qrs_pkg::CLS_ONE;
        end else begin
            cls_next = qrs_pkg::CLS_TWO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_side[0].valid <= 1'b0;
        end else if (adv) begin
            sq_side[0].valid <= v1_reg;
        end
        if (adv) begin
            sq_side[0].cls <= cls_next;
            sq_side[0].a   <= a1_reg;
            sq_side[0].b   <= b1_reg;
            sq_d[0]        <= disc[2*CW+2] ? '0 : disc[qrs_pkg::DISC_W-1:0];
        end
    end

    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;

    // Square-root cell chain.
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        qrs_sqrt_cell #(.RT_W(RT_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .side_in  (sq_side[i]),
            .d_in     (sq_d[i]),
            .root_in  (sq_root[i]),
            .rem_in   (sq_rem[i]),
            .side_out (sq_side[i+1]),
            .d_out    (sq_d[i+1]),
            .root_out (sq_root[i+1]),
            .rem_out  (sq_rem[i+1])
        );
    end

    // Numerators -b*2^F +/- s, split into sign and magnitude.
    always_comb begin
        numb    = -({{(NUM_W-CW){sq_side[SQ_STEPS].b[CW-1]}}, sq_side[SQ_STEPS].b}
                    <<< FRAC_BITS);
        nump    = numb + $signed({{(NUM_W-RT_W){1'b0}}, sq_root[SQ_STEPS]});
        numm    = numb - $signed({{(NUM_W-RT_W){1'b0}}, sq_root[SQ_STEPS]});
        twice_a = {sq_side[SQ_STEPS].a[CW-1], sq_side[SQ_STEPS].a, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_side[0].valid <= 1'b0;
        end else if (adv) begin
            dv_side[0].valid <= sq_side[SQ_STEPS].valid;
        end
        if (adv) begin
            dv_side[0].cls   <= sq_side[SQ_STEPS].cls;
            dv_side[0].neg_p <= nump[NUM_W-1] ^ sq_side[SQ_STEPS].a[CW-1];
            dv_side[0].neg_m <= numm[NUM_W-1] ^ sq_side[SQ_STEPS].a[CW-1];
            dv_side[0].den   <= twice_a[DW] ? DW'(-twice_a) : twice_a[DW-1:0];
            dv_dvd[0][0]     <= nump[NUM_W-1] ? MAG_W'(-nump) : nump[MAG_W-1:0];
            dv_dvd[0][1]     <= numm[NUM_W-1] ? MAG_W'(-numm) : numm[MAG_W-1:0];
        end
    end

    assign dv_quo[0] = '0;
    assign dv_rem[0] = '0;

    // Divider cell chain.
    for (genvar j = 0; j < MAG_W; j++) begin : g_div
        qrs_div_cell #(.MAG_W(MAG_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .side_in  (dv_side[j]),
            .dvd_in   (dv_dvd[j]),
            .quo_in   (dv_quo[j]),
            .rem_in   (dv_rem[j]),
            .side_out (dv_side[j+1]),
            .dvd_out  (dv_dvd[j+1]),
            .quo_out  (dv_quo[j+1]),
            .rem_out  (dv_rem[j+1])
        );
    end

    // Apply signs and clear the roots where none exist.
    always_comb begin
        qp_ext = {{(EXT_W-MAG_W){1'b0}}, dv_quo[MAG_W][0]};
        qm_ext = {{(EXT_W-MAG_W){1'b0}}, dv_quo[MAG_W][1]};
        if (dv_side[MAG_W].neg_p) begin
            qp_ext = -qp_ext;
        end
        if (dv_side[MAG_W].neg_m) begin
            qm_ext = -qm_ext;
        end
        if (dv_side[MAG_W].cls == qrs_pkg::CLS_NONE ||
            dv_side[MAG_W].cls == qrs_pkg::CLS_DEGEN) begin
            plus_next  = '0;
            minus_next = '0;
        end else begin
            plus_next  = qp_ext[RW-1:0];
            minus_next = qm_ext[RW-1:0];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_side[MAG_W].valid;
        end
        if (adv) begin
            out_cls_reg   <= dv_side[MAG_W].cls;
            out_plus_reg  <= plus_next;
            out_minus_reg <= minus_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cls_reg;
    assign m_tdata  = {6'd0, out_minus_reg, out_plus_reg};

`ifndef SYNTH
    // No root or a degenerate equation leaves both roots at zero.
    a_zero_roots: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == qrs_pkg::CLS_NONE || m_tuser == qrs_pkg::CLS_DEGEN))
        |-> (m_tdata == '0))
        else $error("roots not cleared for class without roots");

    // A repeated root shows the same value in both fields.
    a_one_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == qrs_pkg::CLS_ONE) |-> (out_plus_reg == out_minus_reg))
        else $error("repeated root differs between fields");

    // A stalled result is held until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // With a nonzero divisor the final remainder of the plus root stays below the divisor.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_side[MAG_W].valid && dv_side[MAG_W].cls != qrs_pkg::CLS_DEGEN)
        |-> (dv_rem[MAG_W][0] < dv_side[MAG_W].den))
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Streams coefficient words into the solver, predicts the class and both
// fixed-point roots of each equation, and checks every result word in order
// while both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: predicts each equation's roots and holds them until they return.
class root_scoreboard;
    typedef struct {
        logic [1:0]  cls;
        logic [32:0] rp;
        logic [32:0] rm;
    } root_t;

    root_t pending[$];
    int    errors;
    int    checked;

    // Digit-by-digit square root of d * 4^16, floored.
    function automatic longint unsigned frac_sqrt(longint unsigned d);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned pair;
        longint unsigned trial;
        root = 0;
        rem  = 0;
        for (int i = 0; i < 33; i++) begin
            pair = (i < 17) ? ((d >> (2 * (16 - i))) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Note an accepted coefficient word and queue its expected result.
    function void note_equation(logic signed [15:0] a, logic signed [15:0] b,
                                logic signed [15:0] c);
        root_t   r;
        longint  disc;
        longint  s;
        longint  num;
        longint  den;
        longint  qp;
        longint  qm;
        r.cls = qrs_pkg::CLS_DEGEN;
        r.rp  = '0;
        r.rm  = '0;
        if (a != 0) begin
            disc = longint'(b) * b - 4 * longint'(a) * c;
            if (disc < 0) begin
                r.cls = qrs_pkg::CLS_NONE;
            end else begin
                r.cls = (disc == 0) ? qrs_pkg::CLS_ONE : qrs_pkg::CLS_TWO;
                s   = (disc == 0) ? 0 : longint'(frac_sqrt(disc));
                num = -longint'(b) * 65536;
                den = 2 * longint'(a);
                qp  = (num + s) / den;
                qm  = (num - s) / den;
                r.rp = qp[32:0];
                r.rm = qm[32:0];
            end
        end
        pending.push_back(r);
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(logic [1:0] cls, logic [71:0] data);
        root_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result cls=%0d data=%h", $time, cls, data);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (cls !== e.cls) begin
            $display("%0t: class expected %0d actual %0d", $time, e.cls, cls);
            errors++;
        end
        if (data[32:0] !== e.rp) begin
            $display("%0t: root_plus expected %h actual %h", $time, e.rp, data[32:0]);
            errors++;
        end
        if (data[65:33] !== e.rm) begin
            $display("%0t: root_minus expected %h actual %h", $time, e.rm, data[65:33]);
            errors++;
        end
        if (data[71:66] !== 6'd0) begin
            $display("%0t: pad expected 0 actual %h", $time, data[71:66]);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int WATCHDOG = 20000;
    localparam int LATENCY  = 72;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [47:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [71:0] m_tdata;
    wire  [1:0]  m_tuser;

    root_scoreboard roots = new();
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_off = 1'b0;
    int  quiet = 0;
    int  n_sent = 0;
    int  n_degen = 0;

    quadratic_root_solver DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver: random stalls, unless a long hold-off is in force.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            roots.check_result(m_tuser, m_tdata);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCHDOG) begin
            $display("quadratic_root_solver test failed");
            $finish;
        end
    end

    // Offer one equation, idling first at random, and wait for acceptance.
    // The valid line stays high after acceptance so that words can follow
    // back to back; it drops only while the sender idles or drains.
    task automatic send_equation(logic signed [15:0] a, logic signed [15:0] b,
                                 logic signed [15:0] c);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        roots.note_equation(a, b, c);
        n_sent++;
        if (a == 0) n_degen++;
    endtask

    // Raw noise, small coefficients, repeated roots, a = 0, extreme a and two-real-root cases.
    task automatic send_random();
        int kind;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        longint bb;
        kind = $urandom_range(9);
        a = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        if (kind < 2) begin
            // Full-range noise.
        end else if (kind < 4) begin
            a = 16'(int'($urandom_range(15)) - 8);
            b = 16'(int'($urandom_range(63)) - 32);
            c = 16'(int'($urandom_range(63)) - 32);
        end else if (kind == 4) begin
            // Repeated root: a*(x-r)^2 with b = -2ar, c = a*r*r.
            a = 16'(int'($urandom_range(200)) - 100);
            bb = longint'($urandom_range(20)) - 10;
            b = 16'(-2 * a * bb);
            c = 16'(a * bb * bb);
        end else if (kind == 5) begin
            a = 0;
        end else if (kind == 6) begin
            a = {$urandom_range(1) ? 1'b1 : 1'b0, 15'h7fff} ^ 16'(kind);
            c = -c;
        end else begin
            // Two real roots with c of opposite sign to a.
            if ((a < 0) == (c < 0)) c = -c;
        end
        send_equation(a, b, c);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (roots.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed extremes and each special case.
        send_idle = 0;
        recv_idle = 0;
        send_equation(0, 5, 7);
        send_equation(0, -32768, 32767);
        send_equation(1, 0, 1);
        send_equation(1, 2, 1);
        send_equation(-1, 2, -1);
        send_equation(1, -3, 2);
        send_equation(-32768, -32768, -32768);
        send_equation(32767, 32767, 32767);
        send_equation(-32768, 0, 32767);
        send_equation(32767, 0, -32768);
        send_equation(1, -32768, -32768);
        send_equation(1, 32767, 0);
        send_equation(-1, -32768, 32767);
        send_equation(1, 0, 0);
        send_equation(-32768, 32767, 0);
        send_equation(2, 1, -1);
        send_equation(3, 0, -2);
        send_equation(-16'sd1, -16'sd1, -16'sd1);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (120) send_random();
        join
        drain();

        send_idle = 29; recv_idle = 75;
        repeat (140) send_random();
        send_idle = 75; recv_idle = 29;
        repeat (140) send_random();
        send_idle = 0; recv_idle = 0;
        repeat (150) send_random();
        drain();
        repeat (LATENCY + 8) @(posedge aclk);

        $display("Sent %0d equations (%0d degenerate), checked %0d results,",
                 n_sent, n_degen, roots.checked);
        $display("with random stalls on both sides and one long output hold-off.");
        if (roots.errors == 0 && roots.pending.size() == 0) begin
            $display("quadratic_root_solver test passed");
        end else begin
            $display("quadratic_root_solver test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
